[hw/rtl/spa_pkg.sv]
// Shared types and constants for the scored pool admission and selection block.
package spa_pkg;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] entry_key;
      logic [15:0] novelty;
      logic [15:0] quality;
      logic        parse_ok;
      logic [31:0] now_seconds;
      logic [15:0] random_a;
      logic [15:0] random_b;
      logic [15:0] random_c;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  reason;
      logic        evicted;
      logic [31:0] evicted_key;
      logic        sample_valid;
      logic [7:0]  sampled_slot;
      logic [31:0] sampled_key;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] novelty;
      logic [15:0] quality;
      logic [31:0] admit_time;
      logic        prot;
   } entry_type;

   // One scored entry leaving the scoring pipeline.
   typedef struct packed {
      logic        valid;
      logic        pend;
      logic [31:0] key;
      logic        prot;
      logic        match;
      logic [31:0] fit;
      logic [32:0] score;
   } scored_type;

   localparam logic [2:0] OP_ADMIT    = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_PROTECT  = 3'd2;
   localparam logic [2:0] OP_SAMPLE   = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [2:0] RSN_OK        = 3'd0;
   localparam logic [2:0] RSN_PARSE     = 3'd1;
   localparam logic [2:0] RSN_DUPLICATE = 3'd2;
   localparam logic [2:0] RSN_QUALITY   = 3'd3;
   localparam logic [2:0] RSN_NOVELTY   = 3'd4;
   localparam logic [2:0] RSN_FULL      = 3'd5;

   localparam logic [1:0] CSR_MIN_QUALITY    = 2'd0;
   localparam logic [1:0] CSR_MIN_NOVELTY    = 2'd1;
   localparam logic [1:0] CSR_MAX_ENTRIES    = 2'd2;
   localparam logic [1:0] CSR_SELECTION_MODE = 2'd3;

   localparam logic [1:0] MODE_WEIGHTED   = 2'd1;
   localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

   localparam logic [15:0] MIN_QUALITY_RESET = 16'd19661;
   localparam logic [8:0]  MAX_ENTRIES_RESET = 9'd256;
   localparam int          MIN_CAP           = 4;

   // Recency bonus = BONUS_WHOLE * d + floor(floor(BONUS_FRAC * d / 8) / 45),
   // where d = AGE_WINDOW - age; the division by 45 uses RECIP_45 >> 23.
   localparam logic [31:0] AGE_WINDOW   = 32'd3600;
   localparam logic [16:0] BONUS_WHOLE  = 17'd119304;
   localparam logic [7:0]  BONUS_FRAC   = 8'd233;
   localparam logic [17:0] RECIP_45     = 18'd186414;
   localparam int          RECIP_SHIFT  = 23;
   localparam logic [31:0] WEIGHT_FLOOR = 32'd4294967;

endpackage

[hw/rtl/spa_score.sv]
// Two-stage scoring pipeline: fitness, key match and recency-weighted eviction score.
module spa_score #(
   parameter int AW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [AW-1:0]        in_idx,
   input  spa_pkg::entry_type   in_entry,
   input  logic [31:0]          cmp_key,
   input  logic [31:0]          now_seconds,
   output spa_pkg::scored_type  sc,
   output logic [AW-1:0]        sc_idx
);

   logic          v2_ff, v3_ff;
   logic [AW-1:0] i2_ff, i3_ff;
   logic [31:0]   key2_ff, key3_ff;
   logic          prot2_ff, prot3_ff;
   logic          match2_ff, match3_ff;
   logic [31:0]   fit2_ff, fit3_ff;
   logic          inwin2_ff;
   logic [28:0]   whole2_ff;
   logic [16:0]   z2_ff;
   logic [28:0]   bonus3_ff;

   logic [31:0]   age;
   logic [11:0]   age_left;
   logic [19:0]   frac_prod;
   logic [35:0]   recip_prod;
   logic [11:0]   frac_q;

   always_comb begin
      age        = now_seconds - in_entry.admit_time;
      age_left   = 12'(AGE_WINDOW_c() - age);
      frac_prod  = 20'(BONUS_FRAC_c()) * 20'(age_left);
      recip_prod = 36'(z2_ff) * 36'(spa_pkg::RECIP_45);
      frac_q     = 12'(recip_prod >> spa_pkg::RECIP_SHIFT);
   end

   function automatic logic [31:0] AGE_WINDOW_c();
      return spa_pkg::AGE_WINDOW;
   endfunction

   function automatic logic [7:0] BONUS_FRAC_c();
      return spa_pkg::BONUS_FRAC;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      i2_ff     <= in_idx;
      key2_ff   <= in_entry.key;
      prot2_ff  <= in_entry.prot;
      match2_ff <= (in_entry.key == cmp_key);
      fit2_ff   <= 32'(in_entry.novelty) * 32'(in_entry.quality);
      inwin2_ff <= (age < spa_pkg::AGE_WINDOW);
      whole2_ff <= 29'(spa_pkg::BONUS_WHOLE) * 29'(age_left);
      z2_ff     <= 17'(frac_prod >> 3);

      i3_ff     <= i2_ff;
      key3_ff   <= key2_ff;
      prot3_ff  <= prot2_ff;
      match3_ff <= match2_ff;
      fit3_ff   <= fit2_ff;
      bonus3_ff <= inwin2_ff ? 29'(whole2_ff + 29'(frac_q)) : 29'd0;
   end

   always_comb begin
      sc.valid = v3_ff;
      sc.pend  = v2_ff | v3_ff;
      sc.key   = key3_ff;
      sc.prot  = prot3_ff;
      sc.match = match3_ff;
      sc.fit   = fit3_ff;
      sc.score = 33'(fit3_ff) + 33'(bonus3_ff);
      sc_idx   = i3_ff;
   end

endmodule

[hw/rtl/scored_pool_admission_and_selection.sv]
// Top level of the scored pool: entry memory, operation sequencer and result register.
//
// Commands enter on req_data when start is high and busy is low; busy stays high
// until the command's single result has been produced. The result appears on
// rsp_data for exactly one cycle with rsp_valid high; the receiver cannot stall.
// Configuration is written through csr_we/csr_index/csr_wdata, only while the block
// is idle (the user's duty; the block does not enforce it); it takes effect at once.
// All entries live in one memory with a registered read port; every pass over the
// pool reads one entry per cycle through a two-stage scoring pipeline.
// Admit/add/protect scan the pool for the key and, when it is full, scan again for
// the lowest-scored unprotected victim, move the last entry into the victim's slot
// unless they are the same, and write the new entry. A sample draws slots directly
// (uniform, or a tournament of three) or, for roulette, sums the weights and then
// walks the pool; clear compacts the protected entries to the bottom.
// A new command can be taken at the edge that takes the result. Reset empties the
// pool and loads the default register values; memory contents are not cleared.
module scored_pool_admission_and_selection #(
   parameter int CAPACITY        = 256,
   parameter int TOURNAMENT_SIZE = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spa_pkg::req_type  req_data,
   output logic              rsp_valid,
   output spa_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int TW = 32 + OW;
   localparam int CW = (OW > 9) ? OW : 9;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_DUP     = 13'b0000000000010,
      ST_VICT    = 13'b0000000000100,
      ST_MOVE_RD = 13'b0000000001000,
      ST_MOVE_WR = 13'b0000000010000,
      ST_WRITE   = 13'b0000000100000,
      ST_SUM     = 13'b0000001000000,
      ST_PICK_A  = 13'b0000010000000,
      ST_PICK_B  = 13'b0000100000000,
      ST_WALK    = 13'b0001000000000,
      ST_DRAW    = 13'b0010000000000,
      ST_CLEAR   = 13'b0100000000000,
      ST_DONE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] min_quality_ff, min_novelty_ff;
   logic [8:0]  max_entries_ff;
   logic [1:0]  mode_ff;

   // Entry memory.
   spa_pkg::entry_type mem [CAPACITY];
   spa_pkg::entry_type rd_data_ff, mem_wdata;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic               rd_v1_ff;
   logic [AW-1:0]      rd_i1_ff;

   // Command context and accumulators.
   spa_pkg::req_type req_ff, req_in;
   logic [2:0]     thr_ff, thr_in;
   logic [AW-1:0]  draw_ff [3];
   logic [AW-1:0]  draw_in [3];
   logic [OW-1:0]  issue_ff, issue_in, lim_ff, lim_in;
   logic [OW-1:0]  occ_ff, occ_in, wptr_ff, wptr_in;
   logic           dup_ff, dup_in, found_ff, found_in;
   logic [32:0]    best_ff, best_in;
   logic [AW-1:0]  victim_ff, victim_in;
   logic [31:0]    evk_ff, evk_in;
   logic           evicted_ff, evicted_in, accepted_ff, accepted_in;
   logic [2:0]     reason_ff, reason_in;
   logic           svalid_ff, svalid_in;
   logic [AW-1:0]  sel_slot_ff, sel_slot_in;
   logic [31:0]    sel_key_ff, sel_key_in;
   logic [31:0]    best_fit_ff, best_fit_in;
   logic           first_ff, first_in;
   logic [TW-1:0]  total_ff, total_in, prod_hi_ff, prod_hi_in;
   logic [31:0]    prod_lo_ff, prod_lo_in;
   logic [TW-1:0]  pick_ff, pick_in, acc_ff, acc_in, acc_new;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   spa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic           issuing, drained, full;
   logic [CW-1:0]  cap_w, max_w;
   logic [31:0]    weight;
   logic [AW-1:0]  last_slot;

   spa_pkg::scored_type sc;
   logic [AW-1:0]       sc_idx;

   function automatic logic [AW-1:0] draw_of(input logic [15:0] r, input logic [OW-1:0] n);
      logic [OW+15:0] p;
      p = (OW+16)'(r) * (OW+16)'(n);
      return p[AW+15:16];
   endfunction

   spa_score #(.AW(AW)) u_score (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rd_v1_ff),
      .in_idx      (rd_i1_ff),
      .in_entry    (rd_data_ff),
      .cmp_key     (req_ff.entry_key),
      .now_seconds (req_ff.now_seconds),
      .sc          (sc),
      .sc_idx      (sc_idx)
   );

   always_comb begin
      max_w = CW'(max_entries_ff);
      if (max_w < CW'(spa_pkg::MIN_CAP)) begin
         cap_w = CW'(spa_pkg::MIN_CAP);
      end else if (max_w > CW'(CAPACITY)) begin
         cap_w = CW'(CAPACITY);
      end else begin
         cap_w = max_w;
      end
      full      = (CW'(occ_ff) >= cap_w);
      weight    = (sc.fit < spa_pkg::WEIGHT_FLOOR) ? spa_pkg::WEIGHT_FLOOR : sc.fit;
      acc_new   = acc_ff + TW'(weight);
      last_slot = AW'(occ_ff - OW'(1));
      issuing   = (state_ff inside {ST_DUP, ST_VICT, ST_SUM, ST_WALK, ST_DRAW, ST_CLEAR})
                  && (issue_ff < lim_ff);
      drained   = !issuing && !rd_v1_ff && !sc.pend;
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      thr_in      = thr_ff;
      draw_in     = draw_ff;
      issue_in    = issue_ff;
      lim_in      = lim_ff;
      occ_in      = occ_ff;
      wptr_in     = wptr_ff;
      dup_in      = dup_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      victim_in   = victim_ff;
      evk_in      = evk_ff;
      evicted_in  = evicted_ff;
      accepted_in = accepted_ff;
      reason_in   = reason_ff;
      svalid_in   = svalid_ff;
      sel_slot_in = sel_slot_ff;
      sel_key_in  = sel_key_ff;
      best_fit_in = best_fit_ff;
      first_in    = first_ff;
      total_in    = total_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      pick_in     = pick_ff;
      acc_in      = acc_ff;
      hit_in      = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we      = 1'b0;
      mem_waddr   = wptr_ff[AW-1:0];
      mem_wdata   = rd_data_ff;

      case (state_ff)
         ST_MOVE_RD: mem_raddr = AW'(occ_ff);
         ST_DRAW:    mem_raddr = draw_ff[issue_ff[1:0]];
         default:    mem_raddr = issue_ff[AW-1:0];
      endcase

      if (issuing) begin
         issue_in = issue_ff + OW'(1);
      end

      // Consume whatever the scoring pipeline delivers in the current pass.
      if (sc.valid) begin
         case (state_ff)
            ST_DUP: begin
               if (sc.match) begin
                  dup_in = 1'b1;
               end
            end
            ST_VICT: begin
               if (!sc.prot && (!found_ff || sc.score < best_ff)) begin
                  found_in  = 1'b1;
                  best_in   = sc.score;
                  victim_in = sc_idx;
                  evk_in    = sc.key;
               end
            end
            ST_SUM: begin
               total_in = total_ff + TW'(weight);
            end
            ST_WALK: begin
               acc_in = acc_new;
               if (!hit_ff) begin
                  sel_slot_in = sc_idx;
                  sel_key_in  = sc.key;
                  hit_in      = (pick_ff <= acc_new);
               end
            end
            ST_DRAW: begin
               first_in = 1'b0;
               if (first_ff || sc.fit > best_fit_ff) begin
                  best_fit_in = sc.fit;
                  sel_slot_in = sc_idx;
                  sel_key_in  = sc.key;
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               issue_in    = '0;
               lim_in      = occ_ff;
               wptr_in     = '0;
               dup_in      = 1'b0;
               found_in    = 1'b0;
               evicted_in  = 1'b0;
               evk_in      = '0;
               accepted_in = 1'b0;
               reason_in   = spa_pkg::RSN_OK;
               svalid_in   = 1'b0;
               sel_slot_in = '0;
               sel_key_in  = '0;
               first_in    = 1'b1;
               total_in    = '0;
               draw_in[0]  = draw_of(req_data.random_a, occ_ff);
               draw_in[1]  = draw_of(req_data.random_b, occ_ff);
               draw_in[2]  = draw_of(req_data.random_c, occ_ff);
               if (req_data.quality < min_quality_ff) begin
                  thr_in = spa_pkg::RSN_QUALITY;
               end else if (req_data.novelty < min_novelty_ff) begin
                  thr_in = spa_pkg::RSN_NOVELTY;
               end else begin
                  thr_in = spa_pkg::RSN_OK;
               end
               case (req_data.operation)
                  spa_pkg::OP_ADMIT, spa_pkg::OP_ADD, spa_pkg::OP_PROTECT: begin
                     if (!req_data.parse_ok) begin
                        reason_in = spa_pkg::RSN_PARSE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_DUP;
                     end
                  end
                  spa_pkg::OP_SAMPLE: begin
                     if (occ_ff == '0) begin
                        state_in = ST_DONE;
                     end else if (mode_ff == spa_pkg::MODE_WEIGHTED) begin
                        state_in = ST_SUM;
                     end else begin
                        if (mode_ff == spa_pkg::MODE_TOURNAMENT) begin
                           lim_in = OW'(TOURNAMENT_SIZE);
                        end else begin
                           lim_in = OW'(1);
                        end
                        state_in = ST_DRAW;
                     end
                  end
                  spa_pkg::OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DUP: begin
            if (drained) begin
               if (dup_ff) begin
                  reason_in = spa_pkg::RSN_DUPLICATE;
                  state_in  = ST_DONE;
               end else if (req_ff.operation == spa_pkg::OP_ADMIT &&
                            thr_ff != spa_pkg::RSN_OK) begin
                  reason_in = thr_ff;
                  state_in  = ST_DONE;
               end else if (full) begin
                  issue_in = '0;
                  state_in = ST_VICT;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_VICT: begin
            if (drained) begin
               if (!found_ff) begin
                  reason_in = spa_pkg::RSN_FULL;
                  state_in  = ST_DONE;
               end else begin
                  evicted_in = 1'b1;
                  occ_in     = occ_ff - OW'(1);
                  state_in   = (victim_ff == last_slot) ? ST_WRITE : ST_MOVE_RD;
               end
            end
         end
         ST_MOVE_RD: begin
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // The last entry fills the hole left by the victim.
            mem_we    = 1'b1;
            mem_waddr = victim_ff;
            mem_wdata = rd_data_ff;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we               = 1'b1;
            mem_waddr            = AW'(occ_ff);
            mem_wdata.key        = req_ff.entry_key;
            mem_wdata.novelty    = (req_ff.operation == spa_pkg::OP_ADMIT) ?
                                   req_ff.novelty : 16'd0;
            mem_wdata.quality    = (req_ff.operation == spa_pkg::OP_ADMIT) ?
                                   req_ff.quality : 16'd0;
            mem_wdata.admit_time = req_ff.now_seconds;
            mem_wdata.prot       = (req_ff.operation == spa_pkg::OP_PROTECT);
            occ_in               = occ_ff + OW'(1);
            accepted_in          = 1'b1;
            state_in             = ST_DONE;
         end
         ST_SUM: begin
            if (drained) begin
               state_in = ST_PICK_A;
            end
         end
         ST_PICK_A: begin
            // The pick product is split at bit 16 so no single multiply is too wide.
            prod_lo_in = 32'(req_ff.random_a) * 32'(total_ff[15:0]);
            prod_hi_in = TW'(req_ff.random_a) * TW'(total_ff[TW-1:16]);
            state_in   = ST_PICK_B;
         end
         ST_PICK_B: begin
            pick_in  = prod_hi_ff + TW'(prod_lo_ff[31:16]);
            acc_in   = '0;
            hit_in   = 1'b0;
            issue_in = '0;
            state_in = ST_WALK;
         end
         ST_WALK, ST_DRAW: begin
            if (drained) begin
               svalid_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_CLEAR: begin
            // Protected entries slide down in order; writes never pass pending reads.
            if (rd_v1_ff && rd_data_ff.prot) begin
               mem_we    = 1'b1;
               mem_waddr = wptr_ff[AW-1:0];
               mem_wdata = rd_data_ff;
               wptr_in   = wptr_ff + OW'(1);
            end
            if (drained) begin
               occ_in   = wptr_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.accepted     = accepted_ff;
            rsp_data_in.reason       = reason_ff;
            rsp_data_in.evicted      = evicted_ff;
            rsp_data_in.evicted_key  = evicted_ff ? evk_ff : 32'd0;
            rsp_data_in.sample_valid = svalid_ff;
            rsp_data_in.sampled_slot = svalid_ff ? 8'(sel_slot_ff) : 8'd0;
            rsp_data_in.sampled_key  = svalid_ff ? sel_key_ff : 32'd0;
            rsp_data_in.entry_count  = 9'(occ_ff);
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         occ_ff         <= '0;
         rd_v1_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         min_quality_ff <= spa_pkg::MIN_QUALITY_RESET;
         min_novelty_ff <= '0;
         max_entries_ff <= spa_pkg::MAX_ENTRIES_RESET;
         mode_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_v1_ff     <= issuing;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               spa_pkg::CSR_MIN_QUALITY:    min_quality_ff <= csr_wdata;
               spa_pkg::CSR_MIN_NOVELTY:    min_novelty_ff <= csr_wdata;
               spa_pkg::CSR_MAX_ENTRIES:    max_entries_ff <= csr_wdata[8:0];
               spa_pkg::CSR_SELECTION_MODE: mode_ff        <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_i1_ff    <= mem_raddr;
      req_ff      <= req_in;
      thr_ff      <= thr_in;
      draw_ff     <= draw_in;
      issue_ff    <= issue_in;
      lim_ff      <= lim_in;
      wptr_ff     <= wptr_in;
      dup_ff      <= dup_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      victim_ff   <= victim_in;
      evk_ff      <= evk_in;
      evicted_ff  <= evicted_in;
      accepted_ff <= accepted_in;
      reason_ff   <= reason_in;
      svalid_ff   <= svalid_in;
      sel_slot_ff <= sel_slot_in;
      sel_key_ff  <= sel_key_in;
      best_fit_ff <= best_fit_in;
      first_ff    <= first_in;
      total_ff    <= total_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      pick_ff     <= pick_in;
      acc_ff      <= acc_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a command is still in progress");

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(CAPACITY))
      else $error("occupancy beyond capacity");

   a_write_room : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (occ_ff < OW'(CAPACITY)))
      else $error("new entry written into a full pool");

   a_accept_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |-> (rsp_data.reason == spa_pkg::RSN_OK))
      else $error("accepted entry reported with a reject reason");

endmodule

[sim/tb.sv]
// Testbench for the scored pool: directed table, then random commands checked by a predictor.
`timescale 1ns / 1ps

module tb;

   localparam int POOL_DEPTH   = 256;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam logic [2:0] OP_SIZE = 3'd5;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] MODE_UNIFORM = 2'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   spa_pkg::req_type req_data = '0;
   logic rsp_valid;
   spa_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   scored_pool_admission_and_selection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state.
   spa_pkg::entry_type pool [POOL_DEPTH];
   int unsigned pool_count;
   logic [15:0] thr_quality;
   logic [15:0] thr_novelty;
   logic [8:0] cap_reg;
   logic [1:0] mode_reg;

   spa_pkg::rsp_type pending_results[$];
   int unsigned errors = 0;
   int unsigned checked = 0;
   int unsigned cycles = 0;
   int unsigned n_evict = 0;
   int unsigned n_sample = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
      errors++;
   endtask

   function automatic logic [63:0] fitness(input int unsigned i);
      return 64'(pool[i].novelty) * 64'(pool[i].quality);
   endfunction

   function automatic logic [63:0] keep_score(input int unsigned i, input logic [31:0] now);
      logic [31:0] age;
      logic [63:0] bonus;
      age = now - pool[i].admit_time;
      bonus = 0;
      if (age < 32'd3600) bonus = (64'd429496730 * 64'(32'd3600 - age)) / 64'd3600;
      return fitness(i) + bonus;
   endfunction

   function automatic int unsigned uniform_slot(input logic [15:0] r);
      return int'((64'(r) * 64'(pool_count)) >> 16);
   endfunction

   function automatic logic [63:0] weight(input int unsigned i);
      logic [63:0] f;
      f = fitness(i);
      return (f < 64'd4294967) ? 64'd4294967 : f;
   endfunction

   function automatic spa_pkg::rsp_type predict_result(input spa_pkg::req_type rq);
      spa_pkg::rsp_type r;
      int unsigned capv, slot, w, i, v, k;
      logic [63:0] total, acc, pick, best_s, s, bf, f;
      logic found;
      logic [15:0] rr[3];
      r = '0;
      if (rq.operation <= spa_pkg::OP_PROTECT) begin
         capv = cap_reg;
         if (capv < spa_pkg::MIN_CAP) capv = spa_pkg::MIN_CAP;
         if (capv > POOL_DEPTH) capv = POOL_DEPTH;
         if (!rq.parse_ok) r.reason = spa_pkg::RSN_PARSE;
         if (r.reason == spa_pkg::RSN_OK)
            for (i = 0; i < pool_count; i++)
               if (pool[i].key == rq.entry_key) begin
                  r.reason = spa_pkg::RSN_DUPLICATE;
                  break;
               end
         if (r.reason == spa_pkg::RSN_OK && rq.operation == spa_pkg::OP_ADMIT) begin
            if (rq.quality < thr_quality) r.reason = spa_pkg::RSN_QUALITY;
            else if (rq.novelty < thr_novelty) r.reason = spa_pkg::RSN_NOVELTY;
         end
         if (r.reason == spa_pkg::RSN_OK && pool_count >= capv) begin
            found = 1'b0;
            best_s = 0;
            v = 0;
            for (i = 0; i < pool_count; i++) begin
               if (pool[i].prot) continue;
               s = keep_score(i, rq.now_seconds);
               if (!found || s < best_s) begin
                  found = 1'b1;
                  best_s = s;
                  v = i;
               end
            end
            if (!found) r.reason = spa_pkg::RSN_FULL;
            else begin
               r.evicted = 1'b1;
               r.evicted_key = pool[v].key;
               pool_count--;
               pool[v] = pool[pool_count];
            end
         end
         if (r.reason == spa_pkg::RSN_OK && pool_count < POOL_DEPTH) begin
            pool[pool_count].key = rq.entry_key;
            pool[pool_count].novelty =
               (rq.operation == spa_pkg::OP_ADMIT) ? rq.novelty : 16'd0;
            pool[pool_count].quality =
               (rq.operation == spa_pkg::OP_ADMIT) ? rq.quality : 16'd0;
            pool[pool_count].admit_time = rq.now_seconds;
            pool[pool_count].prot = (rq.operation == spa_pkg::OP_PROTECT);
            pool_count++;
            r.accepted = 1'b1;
         end
      end else if (rq.operation == spa_pkg::OP_SAMPLE) begin
         if (pool_count > 0) begin
            if (mode_reg == spa_pkg::MODE_WEIGHTED) begin
               total = 0;
               for (i = 0; i < pool_count; i++) total += weight(i);
               pick = (64'(rq.random_a) * total) >> 16;
               acc = 0;
               slot = pool_count - 1;
               for (i = 0; i < pool_count; i++) begin
                  acc += weight(i);
                  if (pick <= acc) begin
                     slot = i;
                     break;
                  end
               end
            end else if (mode_reg == spa_pkg::MODE_TOURNAMENT) begin
               rr[0] = rq.random_a;
               rr[1] = rq.random_b;
               rr[2] = rq.random_c;
               slot = uniform_slot(rr[0]);
               bf = fitness(slot);
               for (k = 1; k < 3; k++) begin
                  v = uniform_slot(rr[k]);
                  f = fitness(v);
                  if (f > bf) begin
                     slot = v;
                     bf = f;
                  end
               end
            end else begin
               slot = uniform_slot(rq.random_a);
            end
            r.sample_valid = 1'b1;
            r.sampled_slot = slot[7:0];
            r.sampled_key = pool[slot].key;
         end
      end else if (rq.operation == spa_pkg::OP_CLEAR) begin
         w = 0;
         for (i = 0; i < pool_count; i++)
            if (pool[i].prot) begin
               pool[w] = pool[i];
               w++;
            end
         pool_count = w;
      end
      r.entry_count = pool_count[8:0];
      return r;
   endfunction

   // Result checker: the receiver cannot stall, so every strobe is a transfer.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result %0h", rsp_data);
            errors++;
         end else begin
            spa_pkg::rsp_type e;
            e = pending_results.pop_front();
            if (rsp_data.accepted !== e.accepted)
               report_mismatch("accepted", 64'(rsp_data.accepted), 64'(e.accepted));
            if (rsp_data.reason !== e.reason)
               report_mismatch("reason", 64'(rsp_data.reason), 64'(e.reason));
            if (rsp_data.evicted !== e.evicted)
               report_mismatch("evicted", 64'(rsp_data.evicted), 64'(e.evicted));
            if (rsp_data.evicted_key !== e.evicted_key)
               report_mismatch("evicted_key", 64'(rsp_data.evicted_key), 64'(e.evicted_key));
            if (rsp_data.sample_valid !== e.sample_valid)
               report_mismatch("sample_valid", 64'(rsp_data.sample_valid),
                               64'(e.sample_valid));
            if (rsp_data.sampled_slot !== e.sampled_slot)
               report_mismatch("sampled_slot", 64'(rsp_data.sampled_slot),
                               64'(e.sampled_slot));
            if (rsp_data.sampled_key !== e.sampled_key)
               report_mismatch("sampled_key", 64'(rsp_data.sampled_key), 64'(e.sampled_key));
            if (rsp_data.entry_count !== e.entry_count)
               report_mismatch("entry_count", 64'(rsp_data.entry_count), 64'(e.entry_count));
            checked++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         spa_pkg::CSR_MIN_QUALITY: thr_quality = val;
         spa_pkg::CSR_MIN_NOVELTY: thr_novelty = val;
         spa_pkg::CSR_MAX_ENTRIES: cap_reg = val[8:0];
         default: mode_reg = val[1:0];
      endcase
   endtask

   // Issues one command after a random gap; the optional typed result is checked
   // against the predictor as a sanity check on the table itself.
   task automatic issue(input spa_pkg::req_type rq, input logic has_typed,
                        input spa_pkg::rsp_type typed);
      int gap;
      spa_pkg::rsp_type e;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      e = predict_result(rq);
      if (has_typed && e !== typed) begin
         $display("table row disagrees with prediction: %0h vs %0h", typed, e);
         errors++;
      end
      pending_results.push_back(e);
      if (e.reason == spa_pkg::RSN_OK && rq.operation <= spa_pkg::OP_PROTECT && e.evicted)
         n_evict++;
      if (rq.operation == spa_pkg::OP_SAMPLE) n_sample++;
      req_data <= rq;
      start <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (600) @(negedge clock);
   endtask

   function automatic spa_pkg::req_type make_req(input logic [2:0] op, input logic [31:0] key,
                                                 input logic [15:0] nov,
                                                 input logic [15:0] qual,
                                                 input logic pok, input logic [31:0] now);
      spa_pkg::req_type rq;
      rq.operation = op;
      rq.entry_key = key;
      rq.novelty = nov;
      rq.quality = qual;
      rq.parse_ok = pok;
      rq.now_seconds = now;
      rq.random_a = 16'($urandom);
      rq.random_b = 16'($urandom);
      rq.random_c = 16'($urandom);
      return rq;
   endfunction

   // Half of the keys come from two small sets so duplicates and existing keys are common; the rest are fully random.
   function automatic logic [31:0] pick_key;
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 40));
         1: return 32'hFFFF_FFC0 | 32'($urandom_range(0, 63));
         default: return $urandom;
      endcase
   endfunction

   typedef struct {
      spa_pkg::req_type rq;
      logic has_typed;
      spa_pkg::rsp_type typed;
   } table_row;

   table_row plan[$];
   int unsigned phase, n, now_base;
   logic [2:0] op;

   function automatic spa_pkg::rsp_type typed_res(input logic acc, input logic [2:0] rsn,
                                                  input logic [8:0] cnt);
      spa_pkg::rsp_type r;
      r = '0;
      r.accepted = acc;
      r.reason = rsn;
      r.entry_count = cnt;
      return r;
   endfunction

   initial begin
      table_row row;
      for (int i = 0; i < POOL_DEPTH; i++) pool[i] = '0;
      pool_count = 0;
      thr_quality = spa_pkg::MIN_QUALITY_RESET;
      thr_novelty = 16'd0;
      cap_reg = spa_pkg::MAX_ENTRIES_RESET;
      mode_reg = MODE_UNIFORM;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      row.has_typed = 1;
      row.rq = make_req(spa_pkg::OP_SAMPLE, 0, 0, 0, 1, 0);
      row.typed = typed_res(0, spa_pkg::RSN_OK, 0); plan.push_back(row);
      row.rq = make_req(OP_SIZE, 0, 0, 0, 1, 0);
      row.typed = typed_res(0, spa_pkg::RSN_OK, 0); plan.push_back(row);
      row.rq = make_req(OP_SPARE_B, 0, 0, 0, 1, 0); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_ADMIT, 32'h1, 16'hFFFF, 16'hFFFF, 0, 0);
      row.typed = typed_res(0, spa_pkg::RSN_PARSE, 0); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_ADMIT, 32'h1, 16'hFFFF, 16'd19660, 1, 0);
      row.typed = typed_res(0, spa_pkg::RSN_QUALITY, 0); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_ADMIT, 32'h1, 16'h0, 16'd19661, 1, 100);
      row.typed = typed_res(1, spa_pkg::RSN_OK, 1); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_ADMIT, 32'h1, 16'hFFFF, 16'hFFFF, 1, 0);
      row.typed = typed_res(0, spa_pkg::RSN_DUPLICATE, 1); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1,
                        32'hFFFF_FFFF);
      row.typed = typed_res(1, spa_pkg::RSN_OK, 2); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_PROTECT, 32'h0, 0, 0, 1, 5000);
      row.typed = typed_res(1, spa_pkg::RSN_OK, 3); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_PROTECT, 32'h0, 0, 0, 0, 5000);
      row.typed = typed_res(0, spa_pkg::RSN_PARSE, 3); plan.push_back(row);
      row.has_typed = 0;
      row.rq = make_req(spa_pkg::OP_ADMIT, 32'hA5A5_5A5A, 16'hFFFF, 16'hFFFF, 1, 3599);
      plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_SAMPLE, 0, 0, 0, 1, 0); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_SAMPLE, 0, 0, 0, 1, 0); row.rq.random_a = 16'hFFFF;
      plan.push_back(row);
      row.rq = make_req(OP_SPARE_A, 0, 0, 0, 1, 0); plan.push_back(row);
      row.rq = make_req(spa_pkg::OP_CLEAR, 0, 0, 0, 1, 0);
      row.has_typed = 1; row.typed = typed_res(0, spa_pkg::RSN_OK, 1); plan.push_back(row);
      foreach (plan[i]) issue(plan[i].rq, plan[i].has_typed, plan[i].typed);
      drain();

      // Novelty threshold at its top, then back to zero.
      write_reg(spa_pkg::CSR_MIN_NOVELTY, 16'hFFFF);
      issue(make_req(spa_pkg::OP_ADMIT, 32'h77, 16'hFFFE, 16'hFFFF, 1, 0), 1,
            typed_res(0, spa_pkg::RSN_NOVELTY, 1));
      drain();

      // Random phases over register settings, small caps to force evictions.
      for (phase = 0; phase < 8; phase++) begin
         write_reg(spa_pkg::CSR_MIN_QUALITY, (phase == 1) ? 16'hFFFF :
                   (phase == 0) ? 16'd0 : 16'($urandom_range(0, 40000)));
         write_reg(spa_pkg::CSR_MIN_NOVELTY, (phase == 2) ? 16'hFFFF :
                   (phase < 2) ? 16'd0 : 16'($urandom_range(0, 20000)));
         case (phase)
            0: write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'd4);
            1: write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'd0);
            2: write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'h1FF);
            3: write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'd256);
            default: write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'($urandom_range(4, 24)));
         endcase
         write_reg(spa_pkg::CSR_SELECTION_MODE, 16'(phase % 4));
         now_base = $urandom;
         n = (phase == 3) ? 90 : 45;
         for (int j = 0; j < n; j++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6: op = spa_pkg::OP_ADMIT;
               7, 8, 9: op = spa_pkg::OP_ADD;
               10: op = spa_pkg::OP_PROTECT;
               11, 12, 13, 14, 15: op = spa_pkg::OP_SAMPLE;
               16: op = ($urandom_range(0, 3) == 0) ? spa_pkg::OP_CLEAR : OP_SIZE;
               default: op = 3'($urandom_range(5, 7));
            endcase
            issue(make_req(op, pick_key(), 16'($urandom), 16'($urandom),
                           $urandom_range(0, 9) != 0,
                           now_base + 32'($urandom_range(0, 5000))),
                  0, '0);
            // Lower the cap mid-phase so occupancy sits above it.
            if (phase == 3 && j == 60) begin
               drain();
               write_reg(spa_pkg::CSR_MAX_ENTRIES, 16'd5);
            end
         end
         drain();
      end

      drain();
      $display("checked %0d results, %0d evictions, %0d samples over 8 register phases",
               checked, n_evict, n_sample);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
